### design/mpd_pkg.sv
package mpd_pkg;

   // header byte values
   localparam logic [7:0] HDR_A = 8'd184;
   localparam logic [7:0] HDR_B = 8'd183;

   // valid motor id range
   localparam logic [7:0] ID_MIN = 8'd1;
   localparam logic [7:0] ID_MAX = 8'd4;

   // packet byte positions of the captured fields
   localparam logic [7:0] IDX_RPM_LO = 8'd5;
   localparam logic [7:0] IDX_RPM_HI = 8'd6;
   localparam logic [7:0] IDX_POS_B0 = 8'd15;
   localparam logic [7:0] IDX_POS_B1 = 8'd16;
   localparam logic [7:0] IDX_POS_B2 = 8'd17;
   localparam logic [7:0] IDX_POS_B3 = 8'd18;
   localparam logic [7:0] IDX_MAX    = 8'd255;

   // register reset values and default data limit
   localparam logic [7:0] MAIN_PID_RESET    = 8'd193;
   localparam logic [3:0] ERROR_LIMIT_RESET = 4'd10;
   localparam int         DATA_LIMIT_DEFAULT = 32;

   // register indexes
   localparam logic [7:0] CSR_MAIN_DATA_PID = 8'd0;
   localparam logic [7:0] CSR_ERROR_LIMIT   = 8'd1;

   // result status codes
   localparam logic [2:0] ST_MAIN_GOOD  = 3'd0;
   localparam logic [2:0] ST_OTHER_GOOD = 3'd1;
   localparam logic [2:0] ST_CSUM_BAD   = 3'd2;
   localparam logic [2:0] ST_ERR_LIMIT  = 3'd3;
   localparam logic [2:0] ST_OVERRUN    = 3'd4;

   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         wheel_id;
      logic signed [15:0] motor_rpm;
      logic signed [31:0] motor_position;
   } result_type;

endpackage

### design/mpd_parser.sv
module mpd_parser
   import mpd_pkg::*;
#(
   parameter int DATA_LIMIT = DATA_LIMIT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_take,
   input  logic [7:0] rx_byte,
   input  logic [7:0] main_data_pid,
   input  logic [3:0] error_limit,
   output logic       res_valid,
   output result_type res
);

   // parse step codes
   localparam logic [2:0] STEP_HDR  = 3'd0;
   localparam logic [2:0] STEP_ID   = 3'd1;
   localparam logic [2:0] STEP_PID  = 3'd2;
   localparam logic [2:0] STEP_LEN  = 3'd3;
   localparam logic [2:0] STEP_DATA = 3'd4;
   localparam logic [2:0] STEP_CSUM = 3'd5;

   localparam logic [7:0] DATA_LIMIT_B = 8'(DATA_LIMIT);

   logic [2:0]  step_ff, step_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  data_expected_ff, data_expected_in;
   logic [7:0]  data_seen_ff, data_seen_in;
   logic [3:0]  error_run_ff, error_run_in;
   logic [2:0]  packet_id_ff, packet_id_in;
   logic [7:0]  packet_pid_ff, packet_pid_in;
   logic [15:0] rpm_ff, rpm_in;
   logic [31:0] position_ff, position_in;

   logic [7:0] sum_next;
   logic [7:0] index_next;
   logic [1:0] header_inc;
   logic [7:0] seen_inc;
   logic [3:0] limit;
   logic       counted_error;
   logic       clear_pkt;

   assign sum_next   = running_sum_ff + rx_byte;
   assign index_next = (byte_index_ff == IDX_MAX) ? byte_index_ff : byte_index_ff + 8'd1;
   assign header_inc = header_count_ff + 2'd1;
   assign seen_inc   = data_seen_ff + 8'd1;
   assign limit      = (error_limit == 4'd0) ? 4'd1 : error_limit;

   // per-byte parse and result decision
   always_comb begin
      step_in          = step_ff;
      header_count_in  = header_count_ff;
      running_sum_in   = running_sum_ff;
      byte_index_in    = byte_index_ff;
      data_expected_in = data_expected_ff;
      data_seen_in     = data_seen_ff;
      error_run_in     = error_run_ff;
      packet_id_in     = packet_id_ff;
      packet_pid_in    = packet_pid_ff;
      rpm_in           = rpm_ff;
      position_in      = position_ff;
      counted_error    = 1'b0;
      clear_pkt        = 1'b0;
      res_valid        = 1'b0;
      res              = '0;

      unique case (step_ff)
         STEP_HDR: begin
            if (rx_byte == HDR_A || rx_byte == HDR_B) begin
               running_sum_in = sum_next;
               byte_index_in  = index_next;
               error_run_in   = 4'd0;
               if (header_inc >= 2'd2) begin
                  header_count_in = 2'd0;
                  step_in         = STEP_ID;
               end else begin
                  header_count_in = header_inc;
               end
            end else begin
               clear_pkt     = 1'b1;
               error_run_in  = error_run_ff + 4'd1;
               counted_error = 1'b1;
            end
         end
         STEP_ID: begin
            if (rx_byte >= ID_MIN && rx_byte <= ID_MAX) begin
               packet_id_in   = rx_byte[2:0];
               running_sum_in = sum_next;
               byte_index_in  = index_next;
               error_run_in   = 4'd0;
               step_in        = STEP_PID;
            end else begin
               clear_pkt     = 1'b1;
               error_run_in  = error_run_ff + 4'd1;
               counted_error = 1'b1;
            end
         end
         STEP_PID: begin
            packet_pid_in  = rx_byte;
            running_sum_in = sum_next;
            byte_index_in  = index_next;
            step_in        = STEP_LEN;
         end
         STEP_LEN: begin
            data_expected_in = rx_byte;
            data_seen_in     = 8'd0;
            running_sum_in   = sum_next;
            byte_index_in    = index_next;
            step_in          = STEP_DATA;
         end
         STEP_DATA: begin
            // little-endian capture of rpm and position bytes
            case (byte_index_ff)
               IDX_RPM_LO: rpm_in[7:0]        = rx_byte;
               IDX_RPM_HI: rpm_in[15:8]       = rx_byte;
               IDX_POS_B0: position_in[7:0]   = rx_byte;
               IDX_POS_B1: position_in[15:8]  = rx_byte;
               IDX_POS_B2: position_in[23:16] = rx_byte;
               IDX_POS_B3: position_in[31:24] = rx_byte;
               default: ;
            endcase
            running_sum_in = sum_next;
            byte_index_in  = index_next;
            data_seen_in   = seen_inc;
            if (seen_inc >= DATA_LIMIT_B) begin
               clear_pkt    = 1'b1;
               res_valid    = 1'b1;
               res.status   = ST_OVERRUN;
               res.wheel_id = packet_id_ff;
            end else if (seen_inc >= data_expected_ff) begin
               step_in = STEP_CSUM;
            end
         end
         STEP_CSUM: begin
            clear_pkt    = 1'b1;
            res_valid    = 1'b1;
            res.wheel_id = packet_id_ff;
            if (sum_next != 8'd0) begin
               res.status = ST_CSUM_BAD;
            end else if (packet_pid_ff == main_data_pid) begin
               res.status         = ST_MAIN_GOOD;
               res.motor_rpm      = rpm_ff;
               res.motor_position = position_ff;
            end else begin
               res.status = ST_OTHER_GOOD;
            end
         end
         default: begin
            clear_pkt = 1'b1;
         end
      endcase

      // run of header or id errors hit the limit
      if (counted_error && error_run_in == limit) begin
         error_run_in = 4'd0;
         clear_pkt    = 1'b1;
         res_valid    = 1'b1;
         res          = '0;
         res.status   = ST_ERR_LIMIT;
      end

      // drop all packet state at packet end or abort
      if (clear_pkt) begin
         step_in          = STEP_HDR;
         header_count_in  = 2'd0;
         running_sum_in   = 8'd0;
         byte_index_in    = 8'd0;
         data_expected_in = 8'd0;
         data_seen_in     = 8'd0;
         packet_id_in     = 3'd0;
         packet_pid_in    = 8'd0;
         rpm_in           = 16'd0;
         position_in      = 32'd0;
      end
   end

   // parse state, advanced once per accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff          <= STEP_HDR;
         header_count_ff  <= 2'd0;
         running_sum_ff   <= 8'd0;
         byte_index_ff    <= 8'd0;
         data_expected_ff <= 8'd0;
         data_seen_ff     <= 8'd0;
         error_run_ff     <= 4'd0;
         packet_id_ff     <= 3'd0;
         packet_pid_ff    <= 8'd0;
         rpm_ff           <= 16'd0;
         position_ff      <= 32'd0;
      end else if (byte_take) begin
         step_ff          <= step_in;
         header_count_ff  <= header_count_in;
         running_sum_ff   <= running_sum_in;
         byte_index_ff    <= byte_index_in;
         data_expected_ff <= data_expected_in;
         data_seen_ff     <= data_seen_in;
         error_run_ff     <= error_run_in;
         packet_id_ff     <= packet_id_in;
         packet_pid_ff    <= packet_pid_in;
         rpm_ff           <= rpm_in;
         position_ff      <= position_in;
      end
   end

`ifndef SYNTHESIS
   // packet id register only ever holds zero or a legal motor id
   assert property (@(posedge clock) disable iff (reset)
      packet_id_ff <= ID_MAX[2:0])
      else $error("packet id out of range");

   // a checksum step is only reached with both headers seen and length taken
   assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_CSUM |-> byte_index_ff >= 8'd5)
      else $error("checksum step reached too early");

   // error run is never left equal to the limit after a counted error byte
   assert property (@(posedge clock) disable iff (reset)
      $past(byte_take) && $past(counted_error) && !$past(reset)
         |-> error_run_ff != $past(limit))
      else $error("error run not cleared at limit");
`endif

endmodule

### design/mpd_out_stage.sv
module mpd_out_stage
   import mpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       push_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop        = out_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   // output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   // occupancy flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTHESIS
   // skid entry only holds a result while the output register is full
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid full with output empty");

   // no new result may arrive while the skid entry is occupied
   assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed into full buffer");

   // an error-limit result never carries a motor id or data
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.status == ST_ERR_LIMIT
         |-> out_data_ff.wheel_id == 3'd0 && out_data_ff.motor_position == 32'sd0)
      else $error("error-limit result with payload");

   // a good main data result always names a legal wheel
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.status == ST_MAIN_GOOD
         |-> out_data_ff.wheel_id != 3'd0)
      else $error("main data result without wheel id");
`endif

endmodule

### design/motor_packet_deframer.sv
// Motor packet deframer.
// req channel: one received serial byte per request (req_rx_byte). Each byte
// advances the packet parser: two header bytes, motor id, pid, length, data
// bytes, checksum. rsp channel: at most one result per byte, carrying status,
// wheel id, rpm and position; rpm and position are nonzero only for a good
// main data packet. csr channel: register writes, index 0 sets the main data
// pid, index 1 the consecutive-error limit; csr_ready is always high and
// other indexes are ignored. Write registers only while the block is idle.
// Throughput: one byte per cycle while req_ready is high. The parse is
// combinational from the packet state registers; its result is registered
// in the output register, or in the skid entry if that is full and unread.
// Stalls: results go into an output register with one skid entry behind it;
// req_ready stays high while that skid entry is free, so bytes keep flowing
// with one result waiting, and drops only when two results are waiting.
// Reset (synchronous, active high): main data pid 193, error limit 10,
// parser hunting for a header, no results pending. No clearing pass is needed;
// the block takes requests as soon as reset is released.
module motor_packet_deframer
   import mpd_pkg::*;
#(
   parameter int DATA_LIMIT = DATA_LIMIT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [2:0]         rsp_wheel_id,
   output logic signed [15:0] rsp_motor_rpm,
   output logic signed [31:0] rsp_motor_position,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [7:0]         csr_data
);

   logic [7:0] main_data_pid_ff;
   logic [3:0] error_limit_ff;
   logic       req_take;
   logic       res_valid;
   result_type res;
   result_type rsp_data;

   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         main_data_pid_ff <= MAIN_PID_RESET;
         error_limit_ff   <= ERROR_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAIN_DATA_PID: main_data_pid_ff <= csr_data;
            CSR_ERROR_LIMIT:   error_limit_ff   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // packet parser
   mpd_parser #(
      .DATA_LIMIT (DATA_LIMIT)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .byte_take     (req_take),
      .rx_byte       (req_rx_byte),
      .main_data_pid (main_data_pid_ff),
      .error_limit   (error_limit_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // result buffering
   mpd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (req_take && res_valid),
      .push_data  (res),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   assign rsp_status         = rsp_data.status;
   assign rsp_wheel_id       = rsp_data.wheel_id;
   assign rsp_motor_rpm      = rsp_data.motor_rpm;
   assign rsp_motor_position = rsp_data.motor_position;

endmodule
